[src/lbd_pkg.sv]
// Shared types, constants and helper functions of the Lagrange basis derivative evaluator.
package lbd_pkg;

   localparam int MAX_NODES = 6;
   localparam int FRAC_BITS = 16;
   localparam int Q_W       = 32;
   localparam int CNT_W     = 3;
   localparam int IDX_W     = 3;
   localparam int ORD_W     = 3;
   localparam int DIFF_W    = Q_W + 1;
   localparam int DIV_W     = DIFF_W + FRAC_BITS;
   localparam int DIVCNT_W  = $clog2(DIV_W + 1);
   localparam int MASK_W    = MAX_NODES;
   localparam int PROD_W    = 2 * Q_W;
   localparam int FACT_W    = 13;
   localparam int SC_W      = Q_W + FACT_W + 1;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;

   localparam logic [Q_W-1:0] Q_ONE = Q_W'(64'd1 << FRAC_BITS);
   localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
   localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(64'd1 << (FRAC_BITS - 1));

   localparam logic [2:0] REG_NODE_COUNT = 3'd0;
   localparam logic [2:0] REG_NODE_FIRST = 3'd1;
   localparam logic [2:0] REG_NODE_LAST  = 3'd6;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_INDEX = 2'd1;
   localparam logic [1:0] STAT_COINC = 2'd2;
   localparam logic [1:0] STAT_SAT   = 2'd3;

   typedef logic [MAX_NODES-1:0][Q_W-1:0] node_arr_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_MASK, ST_FACT, ST_DIV, ST_MUL, ST_MULR,
      ST_ACC, ST_SCALE, ST_SCALER, ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic check;
      logic term_init;
      logic div_start;
      logic mul_go;
      logic mul_fin;
      logic acc;
      logic scale;
      logic scale_fin;
      logic mask_inc;
      logic m_clr;
      logic m_inc;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic high_order;
      logic mask_skip;
      logic mask_last;
      logic m_end;
      logic m_is_i;
      logic div_done;
   } dp_stat_type;

   typedef struct packed {
      logic [Q_W-1:0] val;
      logic           ovf;
   } sat_type;

   function automatic logic [FACT_W-1:0] fact_of(input logic [ORD_W-1:0] k);
      logic [FACT_W-1:0] f;
      unique case (k)
         3'd0:    f = FACT_W'(1);
         3'd1:    f = FACT_W'(1);
         3'd2:    f = FACT_W'(2);
         3'd3:    f = FACT_W'(6);
         3'd4:    f = FACT_W'(24);
         3'd5:    f = FACT_W'(120);
         3'd6:    f = FACT_W'(720);
         default: f = FACT_W'(5040);
      endcase
      return f;
   endfunction

   // Applies a sign to a magnitude and clamps to the signed 32-bit range.
   function automatic sat_type sat_mag(input logic neg, input logic [DIV_W-1:0] m);
      sat_type r;
      if (!neg) begin
         if (m > DIV_W'(Q_MAX)) begin
            r.val = Q_MAX;
            r.ovf = 1'b1;
         end else begin
            r.val = m[Q_W-1:0];
            r.ovf = 1'b0;
         end
      end else begin
         if (m > DIV_W'(Q_MIN)) begin
            r.val = Q_MIN;
            r.ovf = 1'b1;
         end else begin
            r.val = Q_W'(0) - m[Q_W-1:0];
            r.ovf = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic logic [Q_W-1:0] mag32(input logic [Q_W-1:0] v);
      return v[Q_W-1] ? (Q_W'(0) - v) : v;
   endfunction

   function automatic logic [Q_W-1:0] sel_node(input node_arr_type nodes,
                                               input logic [IDX_W-1:0] idx);
      logic [Q_W-1:0] r;
      r = '0;
      for (int n = 0; n < MAX_NODES; n++) begin
         if (idx == IDX_W'(n)) r = nodes[n];
      end
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] c);
      logic [CNT_W-1:0] r;
      if (c < CNT_W'(2)) r = CNT_W'(2);
      else if (c > CNT_W'(MAX_NODES)) r = CNT_W'(MAX_NODES);
      else r = c;
      return r;
   endfunction

endpackage

[src/lbd_div.sv]
// Bit-serial restoring divider for the rounded fixed-point ratio.
module lbd_div
   import lbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIFF_W-1:0] num,
   input  logic [DIFF_W-1:0] den,
   output logic              done,
   output logic              neg,
   output logic [DIV_W-1:0]  quo
);

   logic [DIFF_W:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DIFF_W-1:0] den_ff, den_in;
   logic [DIVCNT_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;

   logic [DIFF_W-1:0] ua, ub;
   logic [DIFF_W:0]   trial;
   logic              ge;

   always_comb begin
      ua = num[DIFF_W-1] ? (DIFF_W'(0) - num) : num;
      ub = den[DIFF_W-1] ? (DIFF_W'(0) - den) : den;
      trial = {rem_ff[DIFF_W-1:0], quo_ff[DIV_W-1]};
      ge = trial >= {1'b0, den_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      neg_in = neg_ff;
      if (start) begin
         // Dividend carries the half-divisor so the quotient comes out rounded.
         rem_in = '0;
         quo_in = {ua, {FRAC_BITS{1'b0}}} + DIV_W'(ub >> 1);
         den_in = ub;
         cnt_in = '0;
         run_in = 1'b1;
         neg_in = num[DIFF_W-1] ^ den[DIFF_W-1];
      end else if (run_ff) begin
         rem_in = ge ? (trial - {1'b0, den_ff}) : trial;
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + DIVCNT_W'(1);
         if (cnt_ff == DIVCNT_W'(DIV_W - 1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign neg = neg_ff;
   assign quo = quo_ff;

endmodule

[src/lbd_dp.sv]
// Datapath: item registers, loop counters, divider, multiplier, accumulator and scaling.
module lbd_dp
   import lbd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  node_arr_type     nodes,
   input  logic [CNT_W-1:0] node_count,
   input  logic [Q_W-1:0]   x_coord,
   input  logic [IDX_W-1:0] basis_index,
   input  logic [ORD_W-1:0] deriv_order,
   output dp_stat_type      stat,
   output logic [Q_W-1:0]   basis_value,
   output logic [1:0]       status
);

   logic [Q_W-1:0]    x_ff, xi_ff, term_ff, sum_ff, f_ff, val_ff;
   logic [IDX_W-1:0]  i_ff, m_ff;
   logic [ORD_W-1:0]  k_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [MASK_W-1:0] mask_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              pneg_ff, flag_ff;
   logic [SC_W-1:0]   sc_ff;
   logic [1:0]        stat_ff;

   logic              div_done, div_neg;
   logic [DIV_W-1:0]  div_quo;
   logic [Q_W-1:0]    nm;
   logic [DIFF_W-1:0] num, den;
   logic              idx_bad, coinc;
   logic [MASK_W:0]   full;
   sat_type           f_sat, m_sat;
   logic [PROD_W-1:0] rnd;
   logic [Q_W:0]      s;
   logic [SC_W-1:0]   sc_max, sc_min;

   always_comb begin
      nm = sel_node(nodes, m_ff);
      num = mask_ff[m_ff] ? DIFF_W'(Q_ONE)
                          : ({x_ff[Q_W-1], x_ff} - {nm[Q_W-1], nm});
      den = {xi_ff[Q_W-1], xi_ff} - {nm[Q_W-1], nm};
      idx_bad = i_ff >= cnt_ff;
      coinc = 1'b0;
      for (int n = 0; n < MAX_NODES; n++) begin
         if ((IDX_W'(n) < cnt_ff) && (IDX_W'(n) != i_ff) && (nodes[n] == xi_ff))
            coinc = 1'b1;
      end
      full = (MASK_W + 1)'(1) << cnt_ff;
      stat.bad = idx_bad | coinc;
      stat.high_order = k_ff >= cnt_ff;
      stat.mask_skip = mask_ff[i_ff] || ($countones(mask_ff) != int'(k_ff));
      stat.mask_last = mask_ff == MASK_W'(full - (MASK_W + 1)'(1));
      stat.m_end = m_ff >= cnt_ff;
      stat.m_is_i = m_ff == i_ff;
      stat.div_done = div_done;
      f_sat = sat_mag(div_neg, div_quo);
      rnd = (prod_ff + RND_HALF) >> FRAC_BITS;
      m_sat = sat_mag(pneg_ff, DIV_W'(rnd));
      s = {sum_ff[Q_W-1], sum_ff} + {term_ff[Q_W-1], term_ff};
      sc_max = SC_W'(Q_MAX);
      sc_min = {{(SC_W-Q_W){1'b1}}, Q_MIN};
   end

   lbd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num),
      .den   (den),
      .done  (div_done),
      .neg   (div_neg),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= x_coord;
         i_ff <= basis_index;
         k_ff <= deriv_order;
         cnt_ff <= clamp_cnt(node_count);
         xi_ff <= sel_node(nodes, basis_index);
         mask_ff <= '0;
         sum_ff <= '0;
         flag_ff <= 1'b0;
      end
      if (cmd.check && (idx_bad || coinc)) begin
         val_ff <= '0;
         stat_ff <= idx_bad ? STAT_INDEX : STAT_COINC;
      end
      if (cmd.mask_inc) mask_ff <= mask_ff + MASK_W'(1);
      if (cmd.m_clr) m_ff <= '0;
      else if (cmd.m_inc) m_ff <= m_ff + IDX_W'(1);
      if (div_done) begin
         f_ff <= f_sat.val;
         if (f_sat.ovf) flag_ff <= 1'b1;
      end
      if (cmd.term_init) term_ff <= Q_ONE;
      else if (cmd.mul_fin) begin
         term_ff <= m_sat.val;
         if (m_sat.ovf) flag_ff <= 1'b1;
      end
      if (cmd.mul_go) begin
         prod_ff <= PROD_W'(mag32(term_ff)) * PROD_W'(mag32(f_ff));
         pneg_ff <= term_ff[Q_W-1] ^ f_ff[Q_W-1];
      end
      if (cmd.acc) begin
         if (s[Q_W] != s[Q_W-1]) begin
            sum_ff <= s[Q_W] ? Q_MIN : Q_MAX;
            flag_ff <= 1'b1;
         end else begin
            sum_ff <= s[Q_W-1:0];
         end
      end
      if (cmd.scale) sc_ff <= SC_W'($signed(sum_ff) * $signed({1'b0, fact_of(k_ff)}));
      if (cmd.scale_fin) begin
         if ($signed(sc_ff) > $signed(sc_max)) begin
            val_ff <= Q_MAX;
            stat_ff <= STAT_SAT;
         end else if ($signed(sc_ff) < $signed(sc_min)) begin
            val_ff <= Q_MIN;
            stat_ff <= STAT_SAT;
         end else begin
            val_ff <= sc_ff[Q_W-1:0];
            stat_ff <= flag_ff ? STAT_SAT : STAT_OK;
         end
      end
   end

   assign basis_value = val_ff;
   assign status = stat_ff;

endmodule

[src/lbd_ctrl.sv]
// Controller state machine that sequences the node-set and factor loops.
module lbd_ctrl
   import lbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  dp_stat_type stat,
   output cmd_type     cmd,
   output logic        busy,
   output logic        done
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_CHECK;
         ST_CHECK: begin
            priority if (stat.bad) state_in = ST_DONE;
            else if (stat.high_order) state_in = ST_SCALE;
            else state_in = ST_MASK;
         end
         ST_MASK: begin
            if (!stat.mask_skip) state_in = ST_FACT;
            else if (stat.mask_last) state_in = ST_SCALE;
         end
         ST_FACT: begin
            priority if (stat.m_end) state_in = ST_ACC;
            else if (!stat.m_is_i) state_in = ST_DIV;
         end
         ST_DIV:    if (stat.div_done) state_in = ST_MUL;
         ST_MUL:    state_in = ST_MULR;
         ST_MULR:   state_in = ST_FACT;
         ST_ACC:    state_in = stat.mask_last ? ST_SCALE : ST_MASK;
         ST_SCALE:  state_in = ST_SCALER;
         ST_SCALER: state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      done = 1'b0;
      unique case (state_ff)
         ST_IDLE:  cmd.load = start;
         ST_CHECK: cmd.check = 1'b1;
         ST_MASK: begin
            if (stat.mask_skip) begin
               cmd.mask_inc = 1'b1;
            end else begin
               cmd.term_init = 1'b1;
               cmd.m_clr = 1'b1;
            end
         end
         ST_FACT: begin
            priority if (stat.m_end) cmd.m_clr = 1'b0;
            else if (stat.m_is_i) cmd.m_inc = 1'b1;
            else cmd.div_start = 1'b1;
         end
         ST_DIV:    cmd.m_clr = 1'b0;
         ST_MUL:    cmd.mul_go = 1'b1;
         ST_MULR: begin
            cmd.mul_fin = 1'b1;
            cmd.m_inc = 1'b1;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            cmd.mask_inc = 1'b1;
         end
         ST_SCALE:  cmd.scale = 1'b1;
         ST_SCALER: cmd.scale_fin = 1'b1;
         ST_DONE:   done = 1'b1;
         default:   done = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

endmodule

[src/lagrange_basis_derivative_eval.sv]
// Top level of the Lagrange basis polynomial and derivative evaluator.
//
// A word is accepted when start is high and busy is low; busy then stays high
// until the result word has been shown, so one word is in flight at a time.
// The result appears on rsp_basis_value and rsp_status for exactly one cycle,
// marked by rsp_valid, and cannot be held off by the receiver. The work is
// set by the node-set loop: every node set of the requested size that leaves
// out the basis node costs (count - 1) factors, and each factor goes through a
// bit-serial divider of 49 steps, with the divider start, the quotient capture
// and a multiply whose product is registered and then rounded. An index or
// coincident-node error goes straight to the result, and an order at or above
// the node count skips the node-set loop and gives zero. Node coordinates and
// the node count are written through the APB port (node_count at byte 0,
// node_0 to node_5 at bytes 4 to 24) and must only change while the block is
// idle. Status 0 means ok, 1 an index outside the node count, 2 a node
// coinciding with the basis node, and 3 that some intermediate value
// saturated.
module lagrange_basis_derivative_eval
   import lbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [Q_W-1:0]    req_x_coord,
   input  logic [IDX_W-1:0]  req_basis_index,
   input  logic [ORD_W-1:0]  req_deriv_order,
   output logic              rsp_valid,
   output logic [Q_W-1:0]    rsp_basis_value,
   output logic [1:0]        rsp_status,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   logic [CNT_W-1:0] count_ff;
   node_arr_type     node_ff;
   logic [2:0]       reg_idx;
   logic             wr_en;
   cmd_type          cmd;
   dp_stat_type      stat;

   // Register index comes from the word address; the byte offset is ignored.
   assign reg_idx = paddr[ADDR_W-1:2];
   assign wr_en = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(2);
         for (int n = 0; n < MAX_NODES; n++) begin
            if (n == 0) node_ff[n] <= Q_W'(0) - Q_ONE;
            else if (n == 1) node_ff[n] <= Q_ONE;
            else node_ff[n] <= '0;
         end
      end else if (wr_en) begin
         if (reg_idx == REG_NODE_COUNT) begin
            count_ff <= pwdata[CNT_W-1:0];
         end
         for (int n = 0; n < MAX_NODES; n++) begin
            if (reg_idx == 3'(n + 1)) node_ff[n] <= pwdata[Q_W-1:0];
         end
      end
   end

   // Reads return the stored register; unused addresses read as zero.
   always_comb begin
      prdata = '0;
      if (reg_idx == REG_NODE_COUNT) begin
         prdata = DATA_W'(count_ff);
      end else if (reg_idx >= REG_NODE_FIRST && reg_idx <= REG_NODE_LAST) begin
         prdata = sel_node(node_ff, IDX_W'(reg_idx - REG_NODE_FIRST));
      end
   end

   lbd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy),
      .done  (rsp_valid)
   );

   lbd_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .nodes       (node_ff),
      .node_count  (count_ff),
      .x_coord     (req_x_coord),
      .basis_index (req_basis_index),
      .deriv_order (req_deriv_order),
      .stat        (stat),
      .basis_value (rsp_basis_value),
      .status      (rsp_status)
   );

endmodule
